[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the tone segment tracker.
// Every macro expects a clk and an active-low rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define TST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication: when ante holds, cons must hold in the next cycle.
`define TST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tst_pkg.sv]
// Package of the tone segment tracker: payload structs, stored segment type and
// register indexes. Used by every module of the block but the slot map; depends on nothing.
package tst_pkg;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW    = 1'b1;

    localparam logic [15:0] U16_MAX = 16'hFFFF;
    localparam logic [16:0] U17_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [6:0]  tone_id;
        logic [6:0]  strength;
        logic [15:0] frame_blocks;
        logic        no_detection;
        logic        frame_end;
    } det_t;

    typedef struct packed {
        logic [6:0]  seg_tone;
        logic        seg_silence;
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic [15:0] seg_blocks;
        logic        seg_last;
        logic        seg_dropped;
    } seg_out_t;

    typedef struct packed {
        logic [6:0]  tone;
        logic        silence;
        logic [15:0] start_idx;
        logic [15:0] end_idx;
        logic [15:0] blocks;
    } seg_rec_t;

endpackage

[rtl/tst_slot_map.sv]
// Tone-to-slot map: a synchronous memory of slot numbers with one valid flop
// per key, cleared all at once. Registered read; depends on nothing else.
module tst_slot_map #(
    parameter int NUM_KEYS = 129,
    parameter int SLOT_W   = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic                        wr_en,
    input  logic                        inval,
    input  logic                        clr,
    input  logic [$clog2(NUM_KEYS)-1:0] key,
    input  logic [SLOT_W-1:0]           wslot,
    output logic [SLOT_W-1:0]           rslot,
    output logic                        rhit
);

    logic [SLOT_W-1:0]   mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[key] <= wslot;
        end
        if (rd_en)
        begin
            rslot <= mem[key];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rhit      <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[key] <= 1'b1;
            end
            else if (inval)
            begin
                valid_reg[key] <= 1'b0;
            end
            if (rd_en)
            begin
                rhit <= valid_reg[key];
            end
        end
    end

endmodule

[rtl/tst_seg_store.sv]
// Segment store: a synchronous memory of segment records with a registered
// read port and one write port. Uses seg_rec_t from tst_pkg.
module tst_seg_store
    import tst_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  seg_rec_t                 wdata,
    output seg_rec_t                 rdata
);

    seg_rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[rd_addr];
        end
    end

endmodule

[rtl/tone_segment_tracker_top.sv]
// Top level of the tone segment tracker: request sequencer around the slot map
// and the segment store. Depends on tst_pkg, tst_slot_map and tst_seg_store.
//
// Usage: detection requests enter on det_valid/det_ready with a det_t payload,
// one at a time. A request with no strong detection needs no memory access;
// one with a strong detection opens or extends a segment through a
// read-modify-write of the slot map and segment store memories. A frame_end
// request adds silence recording and frame totals. When the window total
// reaches blocks_per_window the block walks the stored segments, with a
// further slot map and store pass for each segment carried into the next
// window, and presents one seg_out_t request per segment on
// seg_valid/seg_ready. det_ready stays low during that walk. The output
// register holds a result while the receiver stalls, and the walk waits for
// it. Configuration writes on cfg_we/cfg_idx/cfg_data take effect at once;
// the user must make them while the block is idle, which the block itself does
// not enforce. Reset clears all control state and the slot map valid flags;
// the segment store is not cleared, and no clearing pass is needed.
module tone_segment_tracker_top
    import tst_pkg::*;
#(
    parameter int NUM_TONES    = 128,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        det_valid,
    output logic        det_ready,
    input  det_t        det,
    output logic        seg_valid,
    input  logic        seg_ready,
    output seg_out_t    seg,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [15:0] cfg_data
);

    localparam int NUM_KEYS = NUM_TONES + 1;
    localparam int KEY_W    = $clog2(NUM_KEYS);
    localparam int SLOT_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
    localparam logic [KEY_W-1:0] SIL_KEY = KEY_W'(NUM_TONES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ITEM  = 4'd1;
    localparam logic [3:0] S_REC1  = 4'd2;
    localparam logic [3:0] S_REC2  = 4'd3;
    localparam logic [3:0] S_REC3  = 4'd4;
    localparam logic [3:0] S_FEND  = 4'd5;
    localparam logic [3:0] S_FEND2 = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CQ    = 4'd8;
    localparam logic [3:0] S_CEMIT = 4'd9;
    localparam logic [3:0] S_CNEXT = 4'd10;

    logic [3:0]        state_reg, state_next, ret_reg, ret_next;
    det_t              item_reg, item_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [16:0]       blk_reg, blk_next;
    logic              had_reg, had_next;
    logic [15:0]       fi_reg, fi_next;
    logic [16:0]       wb_reg, wb_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, n_reg, n_next;
    logic              ovf_reg, ovf_next;
    logic [6:0]        thr_reg, thr_next;
    logic [15:0]       bpw_reg, bpw_next;
    logic [15:0]       last_reg, last_next;
    logic [16:0]       carry_reg, carry_next;
    logic              drop_reg, drop_next, mig_reg, mig_next;
    logic [SLOT_W-1:0] idx_reg, idx_next, slot_reg, slot_next;
    seg_rec_t          cseg_reg, cseg_next;
    logic              sv_reg, sv_next;
    seg_out_t          so_reg, so_next;

    logic              map_rd, map_wr, map_inval, map_clr, map_hit;
    logic [SLOT_W-1:0] map_rslot;
    logic              st_rd, st_wr;
    logic [SLOT_W-1:0] st_raddr, st_waddr;
    seg_rec_t          st_wdata, st_rdata;

    logic              present;
    logic [15:0]       fi_inc;
    logic [17:0]       wb_sum;
    logic [16:0]       wb_new;
    logic [17:0]       blk_sum;
    logic [15:0]       blk_sat;
    logic              extend_ok, mig_hit;
    logic [15:0]       adj_blocks;

    tst_slot_map #(
        .NUM_KEYS (NUM_KEYS),
        .SLOT_W   (SLOT_W)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (map_rd),
        .wr_en (map_wr),
        .inval (map_inval),
        .clr   (map_clr),
        .key   (key_reg),
        .wslot (cnt_reg[SLOT_W-1:0]),
        .rslot (map_rslot),
        .rhit  (map_hit)
    );

    tst_seg_store #(
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk     (clk),
        .rd_en   (st_rd),
        .rd_addr (st_raddr),
        .wr_en   (st_wr),
        .wr_addr (st_waddr),
        .wdata   (st_wdata),
        .rdata   (st_rdata)
    );

    assign det_ready = (state_reg == S_IDLE);
    assign seg_valid = sv_reg;
    assign seg       = so_reg;

    assign present = !item_reg.no_detection && (32'(item_reg.tone_id) < NUM_TONES)
                     && (item_reg.strength > thr_reg);
    assign fi_inc  = (fi_reg != U16_MAX) ? fi_reg + 16'd1 : fi_reg;
    assign wb_sum  = {1'b0, wb_reg} + {2'b00, item_reg.frame_blocks};
    assign wb_new  = (wb_sum > {1'b0, U17_MAX}) ? U17_MAX : wb_sum[16:0];
    assign extend_ok = ({1'b0, st_rdata.end_idx} + 17'd1) >= {1'b0, fi_reg};
    assign blk_sum = (state_reg == S_REC3)
                     ? {2'b00, st_rdata.blocks} + {1'b0, blk_reg}
                     : {1'b0, blk_reg};
    assign blk_sat = (blk_sum > {2'b00, U16_MAX}) ? U16_MAX : blk_sum[15:0];
    assign mig_hit = (cseg_reg.end_idx == last_reg) && (carry_reg != 17'd0);
    assign adj_blocks = !mig_hit ? cseg_reg.blocks
                      : (({1'b0, cseg_reg.blocks} > carry_reg)
                         ? cseg_reg.blocks - carry_reg[15:0] : 16'd0);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        item_next  = item_reg;
        key_next   = key_reg;
        blk_next   = blk_reg;
        had_next   = had_reg;
        fi_next    = fi_reg;
        wb_next    = wb_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        thr_next   = thr_reg;
        bpw_next   = bpw_reg;
        last_next  = last_reg;
        carry_next = carry_reg;
        drop_next  = drop_reg;
        mig_next   = mig_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        cseg_next  = cseg_reg;
        sv_next    = sv_reg;
        so_next    = so_reg;
        map_rd     = 1'b0;
        map_wr     = 1'b0;
        map_inval  = 1'b0;
        map_clr    = 1'b0;
        st_rd      = 1'b0;
        st_wr      = 1'b0;
        st_raddr   = idx_reg;
        st_waddr   = slot_reg;
        st_wdata   = st_rdata;

        if (sv_reg && seg_ready)
        begin
            sv_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_idx == REG_THRESHOLD)
            begin
                thr_next = cfg_data[6:0];
            end
            else
            begin
                bpw_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (det_valid)
                begin
                    item_next  = det;
                    state_next = S_ITEM;
                end
            end
            S_ITEM:
            begin
                if (present)
                begin
                    had_next   = 1'b1;
                    key_next   = KEY_W'(item_reg.tone_id);
                    blk_next   = {1'b0, item_reg.frame_blocks};
                    ret_next   = item_reg.frame_end ? S_FEND : S_IDLE;
                    state_next = S_REC1;
                end
                else
                begin
                    state_next = item_reg.frame_end ? S_FEND : S_IDLE;
                end
            end
            S_REC1:
            begin
                map_rd     = 1'b1;
                state_next = S_REC2;
            end
            S_REC2, S_REC3:
            begin
                if (state_reg == S_REC2 && map_hit)
                begin
                    st_rd      = 1'b1;
                    st_raddr   = map_rslot;
                    slot_next  = map_rslot;
                    state_next = S_REC3;
                end
                else if (state_reg == S_REC3 && extend_ok)
                begin
                    st_wr            = 1'b1;
                    st_wdata.end_idx = fi_reg;
                    st_wdata.blocks  = blk_sat;
                    state_next       = ret_reg;
                end
                else if (cnt_reg >= CNT_W'(MAX_SEGMENTS))
                begin
                    map_inval  = 1'b1;
                    ovf_next   = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    map_wr             = 1'b1;
                    st_wr              = 1'b1;
                    st_waddr           = cnt_reg[SLOT_W-1:0];
                    st_wdata.silence   = (key_reg == SIL_KEY);
                    st_wdata.tone      = (key_reg == SIL_KEY) ? 7'd0 : 7'(key_reg);
                    st_wdata.start_idx = fi_reg;
                    st_wdata.end_idx   = fi_reg;
                    st_wdata.blocks    = (blk_reg > {1'b0, U16_MAX}) ? U16_MAX : blk_reg[15:0];
                    cnt_next           = cnt_reg + CNT_W'(1);
                    state_next         = ret_reg;
                end
            end
            S_FEND:
            begin
                if (!had_reg)
                begin
                    key_next   = SIL_KEY;
                    blk_next   = {1'b0, item_reg.frame_blocks};
                    ret_next   = S_FEND2;
                    state_next = S_REC1;
                end
                else
                begin
                    state_next = S_FEND2;
                end
            end
            S_FEND2:
            begin
                had_next = 1'b0;
                if (wb_new >= {1'b0, bpw_reg})
                begin
                    n_next     = cnt_reg;
                    last_next  = fi_inc - 16'd1;
                    carry_next = (wb_new > {1'b0, bpw_reg}) ? wb_new - {1'b0, bpw_reg} : 17'd0;
                    wb_next    = (wb_new > {1'b0, bpw_reg}) ? wb_new - {1'b0, bpw_reg} : 17'd0;
                    drop_next  = ovf_reg;
                    map_clr    = 1'b1;
                    cnt_next   = '0;
                    fi_next    = 16'd0;
                    ovf_next   = 1'b0;
                    mig_next   = 1'b0;
                    idx_next   = '0;
                    state_next = (cnt_reg == '0) ? S_IDLE : S_CRD;
                end
                else
                begin
                    fi_next    = fi_inc;
                    wb_next    = wb_new;
                    state_next = S_IDLE;
                end
            end
            S_CRD:
            begin
                st_rd      = 1'b1;
                state_next = S_CQ;
            end
            S_CQ:
            begin
                cseg_next  = st_rdata;
                state_next = S_CEMIT;
            end
            S_CEMIT:
            begin
                if (!sv_reg || seg_ready)
                begin
                    sv_next             = 1'b1;
                    so_next.seg_tone    = cseg_reg.tone;
                    so_next.seg_silence = cseg_reg.silence;
                    so_next.seg_start   = cseg_reg.start_idx;
                    so_next.seg_end     = cseg_reg.end_idx;
                    so_next.seg_blocks  = adj_blocks;
                    so_next.seg_last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg);
                    so_next.seg_dropped = drop_reg;
                    if (mig_hit)
                    begin
                        mig_next   = 1'b1;
                        key_next   = cseg_reg.silence ? SIL_KEY : KEY_W'(cseg_reg.tone);
                        blk_next   = carry_reg;
                        ret_next   = S_CNEXT;
                        state_next = S_REC1;
                    end
                    else
                    begin
                        state_next = S_CNEXT;
                    end
                end
            end
            S_CNEXT:
            begin
                if ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg)
                begin
                    fi_next    = mig_reg ? 16'd1 : 16'd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_W'(1);
                    state_next = S_CRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            had_reg   <= 1'b0;
            fi_reg    <= 16'd0;
            wb_reg    <= 17'd0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            thr_reg   <= 7'd50;
            bpw_reg   <= 16'd0;
            drop_reg  <= 1'b0;
            mig_reg   <= 1'b0;
            idx_reg   <= '0;
            sv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            had_reg   <= had_next;
            fi_reg    <= fi_next;
            wb_reg    <= wb_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            thr_reg   <= thr_next;
            bpw_reg   <= bpw_next;
            drop_reg  <= drop_next;
            mig_reg   <= mig_next;
            idx_reg   <= idx_next;
            sv_reg    <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        key_reg   <= key_next;
        blk_reg   <= blk_next;
        last_reg  <= last_next;
        carry_reg <= carry_next;
        slot_reg  <= slot_next;
        cseg_reg  <= cseg_next;
        so_reg    <= so_next;
    end

endmodule

[rtl/tst_checker.sv]
// Port-level checker for the tone segment tracker, bound to the top level.
// Depends on tst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tst_checker
    import tst_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     det_valid,
    input logic     det_ready,
    input logic     seg_valid,
    input logic     seg_ready,
    input seg_out_t seg
);

    `TST_ASSERT_NXT(a_seg_hold, seg_valid && !seg_ready, seg_valid && $stable(seg), "result changed while stalled")
    `TST_ASSERT_NXT(a_one_at_a_time, det_valid && det_ready, !det_ready, "request taken while busy")
    `TST_ASSERT_IMP(a_silence_tone, seg_valid && seg.seg_silence, seg.seg_tone == 7'd0, "silence with tone")
    `TST_ASSERT_IMP(a_span_order, seg_valid, seg.seg_start <= seg.seg_end, "segment ends before it starts")

endmodule

bind tone_segment_tracker_top tst_checker u_tst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .det_valid (det_valid),
    .det_ready (det_ready),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
);

[tb/sv/tb_tone_segment_tracker_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of tone_segment_tracker_top: detection requests are driven
// with random gaps, and segment results are checked against an in-bench predictor.
// Depends on tst_pkg and the tracker RTL.
module tb_tone_segment_tracker_top;
    import tst_pkg::*;

    localparam int TONES = 128;
    localparam int SEGS = 64;
    localparam int SIL_KEY = TONES;

    logic clk;
    logic rst_n;
    logic det_valid;
    logic det_ready;
    det_t det;
    logic seg_valid;
    logic seg_ready;
    seg_out_t seg;
    logic cfg_we;
    logic cfg_idx;
    logic [15:0] cfg_data;

    tone_segment_tracker_top uut (
        .clk(clk), .rst_n(rst_n),
        .det_valid(det_valid), .det_ready(det_ready), .det(det),
        .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    det_t pending_dets[$];
    seg_out_t expected_segs[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    bit det_taken = 0;
    bit no_idle = 0;
    int send_gap = 0;
    int recv_stall = 0;

    int thr;
    int win_size;
    bit slot_ok[0:TONES];
    int slot_of[0:TONES];
    seg_rec_t store[0:SEGS-1];
    int seg_cnt;
    int frm_idx;
    int win_sum;
    bit had_tone;
    bit ovf;

    function automatic logic [15:0] sat16(int a, int b);
        return (a + b > 65535) ? 16'hFFFF : 16'(a + b);
    endfunction

    function automatic void record_tone(int key, int blk);
        bit need;
        int s;
        need = 1;
        if (slot_ok[key] && slot_of[key] < seg_cnt)
        begin
            if (int'(store[slot_of[key]].end_idx) + 1 >= frm_idx)
                need = 0;
        end
        if (need)
        begin
            slot_ok[key] = 0;
            if (seg_cnt >= SEGS)
            begin
                ovf = 1;
                return;
            end
            slot_of[key] = seg_cnt;
            slot_ok[key] = 1;
            store[seg_cnt].silence = (key == SIL_KEY);
            store[seg_cnt].tone = (key == SIL_KEY) ? 7'd0 : 7'(key);
            store[seg_cnt].start_idx = 16'(frm_idx);
            store[seg_cnt].blocks = 16'd0;
            seg_cnt++;
        end
        s = slot_of[key];
        store[s].end_idx = 16'(frm_idx);
        store[s].blocks = sat16(store[s].blocks, blk);
    endfunction

    function automatic void close_window();
        seg_rec_t old[0:SEGS-1];
        seg_out_t o;
        int n;
        int last;
        int carry;
        bit dropped;
        bit moved;
        old = store;
        n = seg_cnt;
        last = (frm_idx == 0) ? 0 : frm_idx - 1;
        carry = (win_sum > win_size) ? win_sum - win_size : 0;
        dropped = ovf;
        moved = 0;
        foreach (slot_ok[k])
            slot_ok[k] = 0;
        seg_cnt = 0;
        frm_idx = 0;
        ovf = 0;
        win_sum = carry;
        if (carry > 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (int'(old[i].end_idx) == last)
                begin
                    old[i].blocks = (old[i].blocks > carry) ? 16'(old[i].blocks - carry) : 16'd0;
                    record_tone(old[i].silence ? SIL_KEY : int'(old[i].tone), carry);
                    moved = 1;
                end
            end
        end
        if (moved)
            frm_idx = 1;
        for (int i = 0; i < n; i++)
        begin
            o.seg_tone = old[i].tone;
            o.seg_silence = old[i].silence;
            o.seg_start = old[i].start_idx;
            o.seg_end = old[i].end_idx;
            o.seg_blocks = old[i].blocks;
            o.seg_last = (i + 1 == n);
            o.seg_dropped = dropped;
            expected_segs.push_back(o);
        end
    endfunction

    function automatic void predict_det(det_t d);
        if (!d.no_detection && int'(d.strength) > thr)
        begin
            had_tone = 1;
            record_tone(int'(d.tone_id), int'(d.frame_blocks));
        end
        if (d.frame_end)
        begin
            if (!had_tone)
                record_tone(SIL_KEY, int'(d.frame_blocks));
            had_tone = 0;
            if (frm_idx < 65535)
                frm_idx++;
            win_sum += int'(d.frame_blocks);
            if (win_sum > 131071)
                win_sum = 131071;
            if (win_sum >= win_size)
                close_window();
        end
    endfunction

    always @(posedge clk)
    begin
        if (det_valid && det_ready)
        begin
            predict_det(det);
            det_taken = 1;
            sent++;
        end
        if (seg_valid && seg_ready)
        begin
            recv_stall = no_idle ? 0 : $urandom_range(0, 15);
            if (expected_segs.size() == 0)
            begin
                $error("unexpected segment result %p", seg);
                errors++;
            end
            else
            begin
                seg_out_t e;
                e = expected_segs.pop_front();
                checked++;
                if (seg.seg_tone !== e.seg_tone)
                begin
                    $error("seg_tone expected %0d got %0d", e.seg_tone, seg.seg_tone);
                    errors++;
                end
                if (seg.seg_silence !== e.seg_silence)
                begin
                    $error("seg_silence expected %0d got %0d", e.seg_silence, seg.seg_silence);
                    errors++;
                end
                if (seg.seg_start !== e.seg_start)
                begin
                    $error("seg_start expected %0d got %0d", e.seg_start, seg.seg_start);
                    errors++;
                end
                if (seg.seg_end !== e.seg_end)
                begin
                    $error("seg_end expected %0d got %0d", e.seg_end, seg.seg_end);
                    errors++;
                end
                if (seg.seg_blocks !== e.seg_blocks)
                begin
                    $error("seg_blocks expected %0d got %0d", e.seg_blocks, seg.seg_blocks);
                    errors++;
                end
                if (seg.seg_last !== e.seg_last)
                begin
                    $error("seg_last expected %0d got %0d", e.seg_last, seg.seg_last);
                    errors++;
                end
                if (seg.seg_dropped !== e.seg_dropped)
                begin
                    $error("seg_dropped expected %0d got %0d", e.seg_dropped, seg.seg_dropped);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!det_valid || det_taken)
            begin
                det_taken = 0;
                if (send_gap > 0)
                begin
                    det_valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_dets.size() > 0)
                begin
                    det <= pending_dets.pop_front();
                    det_valid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 15);
                end
                else
                    det_valid <= 1'b0;
            end
            if (recv_stall > 0)
            begin
                seg_ready <= 1'b0;
                recv_stall--;
            end
            else
                seg_ready <= 1'b1;
        end
    end

    task automatic add_det(int tone, int str, int blk, bit nodet, bit fend);
        det_t d;
        d.tone_id = 7'(tone);
        d.strength = 7'(str);
        d.frame_blocks = 16'(blk);
        d.no_detection = nodet;
        d.frame_end = fend;
        pending_dets.push_back(d);
    endtask

    task automatic drain();
        wait (pending_dets.size() == 0 && !det_valid && expected_segs.size() == 0);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= 16'(value);
        if (idx == REG_THRESHOLD)
            thr = value & 8'h7F;
        else
            win_size = value & 16'hFFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_frame(int max_blk);
        int n;
        int blk;
        n = $urandom_range(1, 4);
        blk = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, max_blk);
        for (int i = 0; i < n; i++)
        begin
            add_det(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5),
                $urandom_range(0, 100), (i == n - 1) ? blk : $urandom_range(0, 65535),
                $urandom_range(0, 7) == 0, i == n - 1);
        end
    endtask

    initial
    begin
        det_valid = 1'b0;
        det = '0;
        seg_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_THRESHOLD;
        cfg_data = 16'd0;
        thr = 50;
        win_size = 0;
        foreach (slot_ok[k])
        begin
            slot_ok[k] = 0;
            slot_of[k] = 0;
        end
        seg_cnt = 0;
        frm_idx = 0;
        win_sum = 0;
        had_tone = 0;
        ovf = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: every frame closes its window.
        add_det(0, 51, 1, 0, 1);
        add_det(127, 100, 65535, 0, 1);
        add_det(9, 50, 7, 0, 1);
        add_det(9, 100, 3, 1, 1);
        add_det(3, 90, 5, 0, 0);
        add_det(3, 90, 0, 0, 0);
        add_det(3, 90, 4, 0, 1);
        drain();
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_WINDOW, 100);
        add_det(1, 1, 60, 0, 1);
        add_det(1, 0, 60, 0, 1);
        add_det(2, 1, 30, 0, 1);
        add_det(2, 1, 60000, 0, 1);
        drain();
        write_reg(REG_THRESHOLD, 100);
        add_det(4, 100, 120, 0, 1);
        drain();
        // Fill the store past its capacity in one window.
        write_reg(REG_THRESHOLD, 10);
        write_reg(REG_WINDOW, 65535);
        for (int i = 0; i < 70; i++)
            add_det(i, 100, 2, 0, i == 69);
        add_det(0, 100, 65535, 0, 1);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            no_idle = (p % 3 == 2);
            write_reg(REG_THRESHOLD, (p == 0) ? 100 : (p == 1) ? 0 : $urandom_range(0, 100));
            write_reg(REG_WINDOW, (p == 3) ? 0 : (p == 5) ? 65535 : $urandom_range(1, 300));
            for (int f = 0; f < 3; f++)
                random_frame(120);
            drain();
        end
        // Close whatever window is still open.
        write_reg(REG_WINDOW, 0);
        add_det(0, 0, 0, 1, 1);
        drain();

        $display("Sent %0d detection requests; checked %0d segment results.", sent, checked);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tst_pkg.sv
rtl/tst_slot_map.sv
rtl/tst_seg_store.sv
rtl/tone_segment_tracker_top.sv
rtl/tst_checker.sv
tb/sv/tb_tone_segment_tracker_top.sv
